// File: hw/rtl/tkn_pkg.sv
// Shared constants and types for the k-nearest sorted list.
`default_nettype none
package tkn_pkg;

  localparam int MAX_K     = 16;
  localparam int ID_BITS   = 16;
  localparam int DIST_BITS = 32;
  localparam int K_BITS    = 5;
  localparam int RANK_BITS = 4;
  localparam int CNT_BITS  = $clog2(MAX_K + 1);
  localparam int CMP_BITS  = (K_BITS > CNT_BITS) ? K_BITS : CNT_BITS;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  // register index, taken from paddr[2]
  localparam logic REG_K_COUNT = 1'b0;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [DIST_BITS-1:0] metric;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic   insert;
    logic   shift_out;
    entry_t cand;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/tkn_cell.sv
// One slot of the sorted list: compares against the candidate and shifts with neighbors.
`default_nettype none
module tkn_cell (
  input  wire logic               clk,
  input  wire tkn_pkg::cell_ctrl_t ctrl,
  input  wire logic               occupied,
  input  wire logic               append_here,
  input  wire logic               gt_left,
  input  wire tkn_pkg::entry_t    left,
  input  wire tkn_pkg::entry_t    right,
  output logic                    gt,
  output tkn_pkg::entry_t         data
);

  tkn_pkg::entry_t data_next;

  // held entry is strictly farther than the candidate
  assign gt = occupied && (data.metric > ctrl.cand.metric);

  always_comb begin
    data_next = data;
    if (ctrl.shift_out) begin
      data_next = right;
    end else if (ctrl.insert) begin
      if (gt_left) begin
        data_next = left;
      end else if (gt || append_here) begin
        data_next = ctrl.cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

// File: hw/rtl/tkn_apb_regs.sv
// APB register file holding the k_count setting.
`default_nettype none
module tkn_apb_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tkn_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  wire logic [tkn_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic      [tkn_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                     pready,
  output logic      [tkn_pkg::K_BITS-1:0]          k_count
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == tkn_pkg::REG_K_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_count <= '0;
    end else if (wr_en) begin
      k_count <= pwdata[tkn_pkg::K_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tkn_pkg::REG_K_COUNT) begin
      prdata[tkn_pkg::K_BITS-1:0] = k_count;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/top_k_nearest_list.sv
// Top level: chain of list cells, insert/flush control and output register.
// Insert: accepted in any idle cycle, one per cycle; the list updates at the accepting edge.
// Flush: one result per cycle from the chain's head while the output is not stalled (one
// empty marker if the list is empty), shifting the chain left one slot per beat; no input
// accepted meanwhile. The state register enters flush first, then results are registered.
// Reset (rst, synchronous): list empty, k_count zero, no result pending.
`default_nettype none
module top_k_nearest_list (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                op,
  input  wire logic [tkn_pkg::ID_BITS-1:0]         cand_id,
  input  wire logic [tkn_pkg::DIST_BITS-1:0]       distance,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [tkn_pkg::ID_BITS-1:0]         object_id_res,
  output logic      [tkn_pkg::DIST_BITS-1:0]       distance_res,
  output logic      [tkn_pkg::RANK_BITS-1:0]       rank,
  output logic                                     empty_res,
  output logic                                     last,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tkn_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  wire logic [tkn_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic      [tkn_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                     pready
);

  typedef enum logic {ST_IDLE, ST_FLUSH} state_t;

  state_t                          state;
  logic [tkn_pkg::CNT_BITS-1:0]    count;
  logic [tkn_pkg::CNT_BITS-1:0]    count_next;
  logic [tkn_pkg::CNT_BITS-1:0]    flush_left;
  logic [tkn_pkg::RANK_BITS-1:0]   rank_ctr;
  logic [tkn_pkg::K_BITS-1:0]      k_count;
  logic [tkn_pkg::CNT_BITS-1:0]    eff_k;

  tkn_pkg::cell_ctrl_t             ctrl;
  tkn_pkg::entry_t                 cell_data [tkn_pkg::MAX_K];
  logic [tkn_pkg::MAX_K-1:0]       gt;
  logic                            placed;
  logic                            append;
  logic                            accept;
  logic                            slot_free;
  logic                            emit;

  tkn_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .k_count (k_count)
  );

  // values above the list depth act as the depth
  assign eff_k = (tkn_pkg::CMP_BITS'(k_count) > tkn_pkg::CMP_BITS'(tkn_pkg::MAX_K))
               ? tkn_pkg::CNT_BITS'(tkn_pkg::MAX_K)
               : tkn_pkg::CNT_BITS'(k_count);

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign emit      = (state == ST_FLUSH) && slot_free;

  assign ctrl.insert      = accept && (op == tkn_pkg::OP_INSERT);
  assign ctrl.shift_out   = emit && (flush_left != '0);
  assign ctrl.cand.id     = cand_id;
  assign ctrl.cand.metric = distance;

  assign placed = |gt;
  assign append = !placed && (count < eff_k)
               && (count < tkn_pkg::CNT_BITS'(tkn_pkg::MAX_K));

  genvar gi;
  generate
    for (gi = 0; gi < tkn_pkg::MAX_K; gi++) begin : g_cell
      logic            occ;
      logic            app_here;
      logic            gt_l;
      tkn_pkg::entry_t left_d;
      tkn_pkg::entry_t right_d;

      assign occ      = count > tkn_pkg::CNT_BITS'(gi);
      assign app_here = append && (count == tkn_pkg::CNT_BITS'(gi));

      if (gi == 0) begin : g_head
        assign gt_l   = 1'b0;
        assign left_d = ctrl.cand;
      end else begin : g_body
        assign gt_l   = gt[gi-1];
        assign left_d = cell_data[gi-1];
      end

      if (gi == tkn_pkg::MAX_K - 1) begin : g_tail
        assign right_d = '0;
      end else begin : g_inner
        assign right_d = cell_data[gi+1];
      end

      tkn_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occ),
        .append_here (app_here),
        .gt_left     (gt_l),
        .left        (left_d),
        .right       (right_d),
        .gt          (gt[gi]),
        .data        (cell_data[gi])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (placed) begin
      // insert plus drop of the farthest keeps the count unless below k
      if (count < eff_k) begin
        count_next = count + tkn_pkg::CNT_BITS'(1);
      end
    end else if (count > eff_k) begin
      count_next = count - tkn_pkg::CNT_BITS'(1);
    end else if (append) begin
      count_next = count + tkn_pkg::CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      flush_left <= '0;
      rank_ctr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (op == tkn_pkg::OP_FLUSH) begin
              state      <= ST_FLUSH;
              flush_left <= count;
              rank_ctr   <= '0;
              count      <= '0;
            end else begin
              count <= count_next;
            end
          end
        end
        ST_FLUSH: begin
          if (emit) begin
            if (flush_left == '0) begin
              state <= ST_IDLE;
            end else begin
              flush_left <= flush_left - tkn_pkg::CNT_BITS'(1);
              rank_ctr   <= rank_ctr + tkn_pkg::RANK_BITS'(1);
              if (flush_left == tkn_pkg::CNT_BITS'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded from the head cell on each flush beat, or zeros with empty_res set
  always_ff @(posedge clk) begin
    if (emit) begin
      if (flush_left == '0) begin
        object_id_res <= '0;
        distance_res  <= '0;
        rank          <= '0;
        empty_res     <= 1'b1;
        last          <= 1'b1;
      end else begin
        object_id_res <= cell_data[0].id;
        distance_res  <= cell_data[0].metric;
        rank          <= rank_ctr;
        empty_res     <= 1'b0;
        last          <= (flush_left == tkn_pkg::CNT_BITS'(1));
      end
    end
  end

endmodule
`default_nettype wire
